>>> hdl/arpc_pkg.sv
// ============================================================================
// arpc_pkg: shared types and codes for the ARP responder with cache
// Probe and write words passed along the cache cell row, protocol codes and
// result status codes.
// ============================================================================
package arpc_pkg;

    // default number of cache slots; slot numbers fit in SLOT_W bits
    localparam int ENTRIES_DEF = 16;
    localparam int SLOT_W      = 8;

    // item kinds carried in the input tuser
    localparam logic [1:0] OP_RECV   = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;

    // ARP header codes
    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [15:0] OPC_REQUEST = 16'h0001;
    localparam logic [15:0] OPC_REPLY   = 16'h0002;

    // result status codes
    localparam logic [3:0] ST_BAD_HW    = 4'd0;
    localparam logic [3:0] ST_BAD_PROTO = 4'd1;
    localparam logic [3:0] ST_REPLIED   = 4'd2;
    localparam logic [3:0] ST_LEARNED   = 4'd3;
    localparam logic [3:0] ST_BAD_OPC   = 4'd4;
    localparam logic [3:0] ST_HIT       = 4'd5;
    localparam logic [3:0] ST_MISS      = 4'd6;
    localparam logic [3:0] ST_UPDATED   = 4'd7;
    localparam logic [3:0] ST_FULL      = 4'd8;

    // configuration register indexes (paddr[3])
    localparam logic REG_OWN_MAC = 1'b0;
    localparam logic REG_OWN_IP  = 1'b1;

    // search word walking down the cell row
    typedef struct packed {
        logic              valid;
        logic [31:0]       ip;
        logic              hit;
        logic [SLOT_W-1:0] hit_slot;
        logic [47:0]       hit_mac;
        logic              free;
        logic [SLOT_W-1:0] free_slot;
    } t_probe;

    // slot write broadcast to every cell
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       ip;
        logic [47:0]       mac;
    } t_wr;

endpackage

>>> hdl/arp_responder_with_cache_unit.sv
// ============================================================================
// arp_responder_with_cache_unit: ARP responder with an IPv4-to-MAC cache
// Checks ARP headers, learns sender pairs, answers requests, and serves
// lookups and updates on a row of ENTRIES cache cells.
// ============================================================================
// Usage:
//   Input words arrive on the s-side stream: tuser is the item kind
//   (received header, lookup, update), tdata carries the header fields.
//   Each word gives exactly one result word on the m-side stream (kind 3 is
//   dropped with no result). own_mac and own_ip are set over the APB port at
//   byte addresses 0 and 8, by the user while the block is idle (not enforced).
//   One word is handled at a time. A search word walks the cell row one cell
//   per cycle, and the next word is accepted once the result of the last one
//   is loaded into the output register.
//   A finished result waits in the output register; the next word is still
//   accepted and searched, and its result waits for the register to free.
//   Reset clears every valid mark of the cache at once and the registers
//   own_mac and own_ip.
// ============================================================================
module arp_responder_with_cache_unit #(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // input stream
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // tdata: hw_type[15:0], proto_type[31:16], arp_opcode[47:32],
    //        sender_mac[95:48], sender_ip[127:96]
    input  logic [127:0]  i_s_tdata,
    // tuser: operation[1:0]
    input  logic [1:0]    i_s_tuser,
    // result stream
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // tdata: reply_dest_mac[47:0], reply_dest_ip[79:48], reply_src_mac[127:80],
    //        reply_src_ip[159:128], reply_opcode[175:160], found_mac[223:176],
    //        entry_slot[227:224], zero fill[231:228]
    output logic [231:0]  o_m_tdata,
    // tuser: status[3:0], send_reply[4]
    output logic [4:0]    o_m_tuser,
    // configuration port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);
    import arpc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state        r_state;
    logic [47:0]   r_own_mac;
    logic [31:0]   r_own_ip;
    logic [1:0]    r_op;
    logic [15:0]   r_hw;
    logic [15:0]   r_proto;
    logic [15:0]   r_opc;
    logic [47:0]   r_mac;
    logic [31:0]   r_ip;
    t_probe        r_res;
    logic          r_m_valid;
    logic [231:0]  r_m_data;
    logic [4:0]    r_m_user;

    t_probe        w_probe [0:ENTRIES];
    t_probe        w_probe_head;
    t_wr           w_wr;
    logic          w_accept;
    logic          w_launch;
    logic          w_done;
    logic          w_learn_do;
    logic          w_learn_ok;
    logic [SLOT_W-1:0] w_learn_slot;
    logic [3:0]    n_status;
    logic          n_send;
    logic [47:0]   n_found;
    logic [3:0]    n_slot;
    logic [231:0]  n_m_data;

    // configuration access
    assign pready = 1'b1;
    assign prdata = (paddr[3] == REG_OWN_IP) ? {32'd0, r_own_ip} : {16'd0, r_own_mac};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac <= 48'd0;
            r_own_ip  <= 32'd0;
        end else if (psel && penable && pwrite) begin
            if (paddr[3] == REG_OWN_MAC) begin
                r_own_mac <= pwdata[47:0];
            end else begin
                r_own_ip  <= pwdata[31:0];
            end
        end
    end

    // input handshake and search launch into the first cell
    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_launch   = w_accept && (i_s_tuser == OP_RECV || i_s_tuser == OP_LOOKUP
                                     || i_s_tuser == OP_UPDATE);

    always_comb begin
        w_probe_head       = '0;
        w_probe_head.valid = w_launch;
        w_probe_head.ip    = i_s_tdata[127:96];
    end

    assign w_probe[0] = w_probe_head;

    // cache cell row
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        arpc_cell #(
            .ID (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_probe (w_probe[g]),
            .i_wr    (w_wr),
            .o_probe (w_probe[g+1])
        );
    end

    // result decision from the finished search
    assign w_done       = (r_state == S_FINISH) && (!r_m_valid || i_m_tready);
    assign w_learn_ok   = r_res.hit || r_res.free;
    assign w_learn_slot = r_res.hit ? r_res.hit_slot : r_res.free_slot;

    always_comb begin
        n_status   = ST_MISS;
        n_send     = 1'b0;
        n_found    = 48'd0;
        n_slot     = 4'd0;
        w_learn_do = 1'b0;
        case (r_op)
            OP_RECV: begin
                if (r_hw != HW_ETHERNET) begin
                    n_status = ST_BAD_HW;
                end else if (r_proto != PROTO_IPV4) begin
                    n_status = ST_BAD_PROTO;
                end else begin
                    w_learn_do = 1'b1;
                    if (r_opc == OPC_REQUEST) begin
                        n_send   = 1'b1;
                        n_status = ST_REPLIED;
                    end else if (r_opc == OPC_REPLY) begin
                        n_status = ST_LEARNED;
                    end else begin
                        n_status = ST_BAD_OPC;
                    end
                    if (!w_learn_ok) begin
                        n_status = ST_FULL;
                    end else begin
                        n_slot = w_learn_slot[3:0];
                    end
                end
            end
            OP_LOOKUP: begin
                if (r_res.hit) begin
                    n_status = ST_HIT;
                    n_found  = r_res.hit_mac;
                    n_slot   = r_res.hit_slot[3:0];
                end else begin
                    n_status = ST_MISS;
                end
            end
            default: begin
                w_learn_do = 1'b1;
                if (w_learn_ok) begin
                    n_status = ST_UPDATED;
                    n_slot   = w_learn_slot[3:0];
                end else begin
                    n_status = ST_FULL;
                end
            end
        endcase
    end

    // broadcast the slot write as the result is loaded
    always_comb begin
        w_wr.en   = w_done && w_learn_do && w_learn_ok;
        w_wr.slot = w_learn_slot;
        w_wr.ip   = r_ip;
        w_wr.mac  = r_mac;
    end

    // pack the result word; reply fields stay zero when nothing is sent
    always_comb begin
        n_m_data = '0;
        if (n_send) begin
            n_m_data[47:0]    = r_mac;
            n_m_data[79:48]   = r_ip;
            n_m_data[127:80]  = r_own_mac;
            n_m_data[159:128] = r_own_ip;
            n_m_data[175:160] = OPC_REPLY;
        end
        n_m_data[223:176] = n_found;
        n_m_data[227:224] = n_slot;
    end

    // sequence one word through search and result, hold the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            if (w_done) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_launch) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_probe[ENTRIES].valid) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        if (w_accept) begin
            r_op    <= i_s_tuser;
            r_hw    <= i_s_tdata[15:0];
            r_proto <= i_s_tdata[31:16];
            r_opc   <= i_s_tdata[47:32];
            r_mac   <= i_s_tdata[95:48];
            r_ip    <= i_s_tdata[127:96];
        end
        if (r_state == S_SCAN && w_probe[ENTRIES].valid) begin
            r_res <= w_probe[ENTRIES];
        end
        if (w_done) begin
            r_m_data <= n_m_data;
            r_m_user <= {n_send, n_status};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

endmodule

>>> hdl/arpc_cell.sv
// ============================================================================
// arpc_cell: one cache slot of the ARP cache row
// Holds one IP/MAC pair with its valid mark, updates the passing search word
// with the first hit and the first free slot, and registers it for the next
// cell.
// ============================================================================
module arpc_cell #(
    parameter int ID = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  arpc_pkg::t_probe i_probe,
    input  arpc_pkg::t_wr    i_wr,
    output arpc_pkg::t_probe o_probe
);
    import arpc_pkg::*;

    localparam logic [SLOT_W-1:0] ID_BITS = SLOT_W'(ID);

    logic        r_valid;
    logic [31:0] r_ip;
    logic [47:0] r_mac;
    t_probe      r_probe;
    t_probe      n_probe;

    // mark the first matching slot and the first free slot
    always_comb begin
        n_probe = i_probe;
        if (!i_probe.hit && r_valid && (r_ip == i_probe.ip)) begin
            n_probe.hit      = 1'b1;
            n_probe.hit_slot = ID_BITS;
            n_probe.hit_mac  = r_mac;
        end
        if (!i_probe.free && !r_valid) begin
            n_probe.free      = 1'b1;
            n_probe.free_slot = ID_BITS;
        end
    end

    // hold the slot contents, take broadcast writes for this slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wr.en && (i_wr.slot == ID_BITS)) begin
            r_valid <= 1'b1;
        end
        if (i_wr.en && (i_wr.slot == ID_BITS)) begin
            r_ip  <= i_wr.ip;
            r_mac <= i_wr.mac;
        end
    end

    // advance the search word to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.valid <= 1'b0;
        end else begin
            r_probe.valid <= n_probe.valid;
        end
        r_probe.ip        <= n_probe.ip;
        r_probe.hit       <= n_probe.hit;
        r_probe.hit_slot  <= n_probe.hit_slot;
        r_probe.hit_mac   <= n_probe.hit_mac;
        r_probe.free      <= n_probe.free;
        r_probe.free_slot <= n_probe.free_slot;
    end

    assign o_probe = r_probe;

endmodule
